@@ sv/gioc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the GNSS indoor/outdoor classifier.
// Used by the controller, the datapath and the top level; depends on nothing.
package gioc_pkg;

   // Default size of the SNR store (satellite ids 1 to SATELLITES).
   localparam int SATELLITES_DEFAULT = 32;

   // Field widths of the request and response items.
   localparam int TIME_W  = 64;
   localparam int ID_W    = 8;
   localparam int SNR_W   = 8;
   localparam int COUNT_W = 6;
   localparam int TOTAL_W = 13;
   localparam int WIN_W   = 32;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TOTAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 2'd2;

   // Configuration reset values.
   localparam logic [COUNT_W-1:0] MIN_COUNT_RESET = 6'd4;
   localparam logic [TOTAL_W-1:0] MIN_TOTAL_RESET = 13'd80;
   localparam logic [WIN_W-1:0]   WINDOW_RESET    = 32'd4000;

   // Classification codes.
   localparam logic [1:0] PLACE_UNDEF   = 2'd0;
   localparam logic [1:0] PLACE_INDOOR  = 2'd1;
   localparam logic [1:0] PLACE_OUTDOOR = 2'd2;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_WALK,
      ST_DRAIN,
      ST_DECIDE,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // take the accepted request into the input registers
      logic eval;      // store the SNR, advance the batch and check the window
      logic walk;      // read one store entry and advance the walk index
      logic decide;    // publish the class and clear the store
      logic load_rsp;  // load the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic classify;   // the request closes the window
      logic walk_last;  // the walk index is at the last entry
      logic rsp_free;   // the response register can take a new response
   } status_type;

endpackage

@@ sv/gnss_indoor_outdoor_classifier.sv @@
`timescale 1ns / 1ps
// GNSS indoor/outdoor classifier, top level: joins controller and datapath.
// A request that does not close the window goes from evaluation straight to the
// response; one that classifies also walks the SNR store, one entry a cycle, then
// drains, decides and responds.
// The next request is taken once the response is loaded, so a stalled response
// holds off the next request.
// Reset is synchronous and active high; it restores default thresholds and empties the store.
module gnss_indoor_outdoor_classifier
   import gioc_pkg::*;
#(
   parameter int SATELLITES = SATELLITES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // time_ms[63:0], satellite_id[71:64], snr_value[79:72]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // batch_end
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // updated[0], place[2:1], seen_count[8:3], snr_total[21:9], zero fill [23:22]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   gioc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gioc_dp #(
      .SATELLITES (SATELLITES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ sv/gioc_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the GNSS indoor/outdoor classifier: sequences one request
// through evaluation, the store walk, the decision and the response. Uses gioc_pkg.
module gioc_ctrl
   import gioc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.classify ? ST_WALK : ST_RESP;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last read entry is added up in this cycle.
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/gioc_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the GNSS indoor/outdoor classifier: configuration registers,
// SNR store, window timer, count and sum accumulators and response register.
// Uses gioc_pkg.
module gioc_dp
   import gioc_pkg::*;
#(
   parameter int SATELLITES = SATELLITES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(SATELLITES);
   localparam int BP_W  = $clog2(SATELLITES + 1);
   localparam int ACC_C_W = BP_W;
   localparam int ACC_T_W = BP_W + SNR_W;
   localparam logic [ID_W-1:0]  ID_MAX   = ID_W'(SATELLITES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SATELLITES - 1);
   localparam logic [BP_W-1:0]  BP_MAX   = BP_W'(SATELLITES);

   // Configuration registers.
   logic [COUNT_W-1:0] min_count_ff, min_count_in;
   logic [TOTAL_W-1:0] min_total_ff, min_total_in;
   logic [WIN_W-1:0]   window_ff, window_in;

   // Captured request.
   logic [TIME_W-1:0] time_ff, time_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [SNR_W-1:0]  snr_ff, snr_in;
   logic              last_ff, last_in;
   logic [TIME_W-1:0] start_cap_ff, start_cap_in;

   // Block state.
   logic [TIME_W-1:0]     start_ff, start_in;
   logic [BP_W-1:0]       bpos_ff, bpos_in;
   logic [SATELLITES-1:0] valid_ff, valid_in;
   logic [1:0]            place_ff, place_in;
   logic [COUNT_W-1:0]    seen_ff, seen_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic                  updated_ff, updated_in;

   // Walk and accumulation.
   logic [IDX_W-1:0]   widx_ff, widx_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [SNR_W-1:0]   rd_data_ff;
   logic               rd_valid_ff;
   logic [ACC_C_W-1:0] acc_cnt_ff, acc_cnt_in;
   logic [ACC_T_W-1:0] acc_tot_ff, acc_tot_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // SNR store.
   logic [SNR_W-1:0] store_mem [SATELLITES];

   logic [TIME_W-1:0]  elapsed;
   logic               store_hit;
   logic [IDX_W-1:0]   wr_addr;
   logic [SNR_W-1:0]   entry;
   logic [COUNT_W-1:0] cnt_sat;
   logic [TOTAL_W-1:0] tot_sat;

   // Window check, store address and saturated results.
   always_comb begin
      elapsed   = time_ff - start_cap_ff;
      store_hit = (bpos_ff < BP_MAX) && (id_ff != '0) && (id_ff <= ID_MAX);
      wr_addr   = IDX_W'(id_ff - ID_W'(1));
      entry     = rd_valid_ff ? rd_data_ff : '0;
      if ((ACC_C_W + COUNT_W)'(acc_cnt_ff) > (ACC_C_W + COUNT_W)'({COUNT_W{1'b1}})) begin
         cnt_sat = {COUNT_W{1'b1}};
      end else begin
         cnt_sat = COUNT_W'(acc_cnt_ff);
      end
      if ((ACC_T_W + TOTAL_W)'(acc_tot_ff) > (ACC_T_W + TOTAL_W)'({TOTAL_W{1'b1}})) begin
         tot_sat = {TOTAL_W{1'b1}};
      end else begin
         tot_sat = TOTAL_W'(acc_tot_ff);
      end
      status.classify  = last_ff && (elapsed > {{(TIME_W - WIN_W){1'b0}}, window_ff});
      status.walk_last = (widx_ff == IDX_LAST);
      status.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   // Next values of all registers.
   always_comb begin
      min_count_in = min_count_ff;
      min_total_in = min_total_ff;
      window_in    = window_ff;
      time_in      = time_ff;
      id_in        = id_ff;
      snr_in       = snr_ff;
      last_in      = last_ff;
      start_cap_in = start_cap_ff;
      start_in     = start_ff;
      bpos_in      = bpos_ff;
      valid_in     = valid_ff;
      place_in     = place_ff;
      seen_in      = seen_ff;
      total_in     = total_ff;
      updated_in   = updated_ff;
      widx_in      = widx_ff;
      rd_pend_in   = cmd.walk;
      acc_cnt_in   = acc_cnt_ff;
      acc_tot_in   = acc_tot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Configuration writes; indexes beyond the list are dropped.
      if (csr_we) begin
         priority case (csr_index)
            CSR_MIN_COUNT: min_count_in = COUNT_W'(csr_wdata);
            CSR_MIN_TOTAL: min_total_in = TOTAL_W'(csr_wdata);
            CSR_WINDOW:    window_in    = csr_wdata;
            default:       ;
         endcase
      end

      // Capture the request; an unset window takes its start from it.
      if (cmd.capture) begin
         time_in      = req_tdata[TIME_W-1:0];
         id_in        = req_tdata[TIME_W +: ID_W];
         snr_in       = req_tdata[TIME_W + ID_W +: SNR_W];
         last_in      = req_tlast;
         start_cap_in = (start_ff == '0) ? req_tdata[TIME_W-1:0] : start_ff;
      end

      // Store the SNR, advance the batch position and open the walk.
      if (cmd.eval) begin
         start_in   = start_cap_ff;
         updated_in = status.classify;
         if (store_hit) begin
            valid_in[wr_addr] = 1'b1;
         end
         if (bpos_ff < BP_MAX) begin
            bpos_in = bpos_ff + BP_W'(1);
         end
         if (last_ff) begin
            bpos_in = '0;
         end
         widx_in    = '0;
         acc_cnt_in = '0;
         acc_tot_in = '0;
      end

      // Step through the store.
      if (cmd.walk) begin
         widx_in = widx_ff + IDX_W'(1);
      end

      // Add up the entry read in the previous cycle.
      if (rd_pend_ff && entry != '0) begin
         acc_cnt_in = acc_cnt_ff + ACC_C_W'(1);
         acc_tot_in = acc_tot_ff + ACC_T_W'(entry);
      end

      // Publish the class, clear the store and restart the window.
      if (cmd.decide) begin
         seen_in  = cnt_sat;
         total_in = tot_sat;
         place_in = (cnt_sat >= min_count_ff && tot_sat >= min_total_ff) ?
                    PLACE_OUTDOOR : PLACE_INDOOR;
         valid_in = '0;
         start_in = time_ff;
      end

      // Response register: freed when taken, loaded at the end of a request.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, total_ff, seen_ff, place_ff, updated_ff};
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_count_ff <= MIN_COUNT_RESET;
         min_total_ff <= MIN_TOTAL_RESET;
         window_ff    <= WINDOW_RESET;
         start_ff     <= '0;
         bpos_ff      <= '0;
         valid_ff     <= '0;
         place_ff     <= PLACE_UNDEF;
         seen_ff      <= '0;
         total_ff     <= '0;
         updated_ff   <= 1'b0;
         widx_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         acc_cnt_ff   <= '0;
         acc_tot_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_count_ff <= min_count_in;
         min_total_ff <= min_total_in;
         window_ff    <= window_in;
         start_ff     <= start_in;
         bpos_ff      <= bpos_in;
         valid_ff     <= valid_in;
         place_ff     <= place_in;
         seen_ff      <= seen_in;
         total_ff     <= total_in;
         updated_ff   <= updated_in;
         widx_ff      <= widx_in;
         rd_pend_ff   <= rd_pend_in;
         acc_cnt_ff   <= acc_cnt_in;
         acc_tot_ff   <= acc_tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      time_ff      <= time_in;
      id_ff        <= id_in;
      snr_ff       <= snr_in;
      last_ff      <= last_in;
      start_cap_ff <= start_cap_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // SNR store: written during evaluation, read with a registered port on the walk.
   always_ff @(posedge clock) begin
      if (cmd.eval && store_hit) begin
         store_mem[wr_addr] <= snr_ff;
      end
      rd_data_ff  <= store_mem[widx_ff];
      rd_valid_ff <= valid_ff[widx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The batch position saturates at the store size.
   a_bpos_range: assert property (@(posedge clock) disable iff (reset)
      bpos_ff <= BP_MAX)
      else $error("batch position beyond store size");

   // A decision leaves the store empty.
   a_store_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> valid_ff == '0)
      else $error("store not cleared after decision");

   // The count never exceeds the number of entries.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      acc_cnt_ff <= BP_MAX)
      else $error("satellite count beyond store size");

   // A response is loaded only into a free register.
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before it was taken");

endmodule

@@ tb/gnss_indoor_outdoor_classifier_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the GNSS indoor/outdoor classifier: directed and random
// satellite report batches, threshold and window settings, random stalls on both streams.
// Depends on gioc_pkg and the gnss_indoor_outdoor_classifier RTL.
module gnss_indoor_outdoor_classifier_test;
   import gioc_pkg::*;

   localparam int N_SAT = SATELLITES_DEFAULT;

   // One satellite report as it is offered on the request stream.
   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic [ID_W-1:0]   sat_id;
      logic [SNR_W-1:0]  snr;
      logic              batch_end;
   } report_type;

   // Response word, laid out as on rsp_tdata (updated in bit 0).
   typedef struct packed {
      logic [1:0]         fill;
      logic [TOTAL_W-1:0] snr_total;
      logic [COUNT_W-1:0] seen_count;
      logic [1:0]         place;
      logic               updated;
   } verdict_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Own copy of the classifier state and its thresholds.
   logic [SNR_W-1:0]   snr_seen [N_SAT];
   logic [TIME_W-1:0]  win_start;
   logic [1:0]         cur_place;
   logic [COUNT_W-1:0] cur_count;
   logic [TOTAL_W-1:0] cur_total;
   int                 batch_pos;
   logic [COUNT_W-1:0] thr_count;
   logic [TOTAL_W-1:0] thr_total;
   logic [WIN_W-1:0]   win_len;

   verdict_type       verdicts_due [$];
   int                misfits = 0;
   logic [TIME_W-1:0] sky_time;
   bit                no_idle = 1'b0;
   bit                hold_rsp = 1'b0;
   bit                holdoff_armed = 1'b0;

   gnss_indoor_outdoor_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Fixed time limit, several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Applies one accepted report to the local state and returns the response it causes.
   function automatic verdict_type judge_report(input report_type r);
      verdict_type v;
      int          seen;
      int          total;
      v = '0;
      if (win_start == '0) win_start = r.time_ms;
      if (batch_pos < N_SAT) begin
         if (r.sat_id >= 1 && r.sat_id <= N_SAT) snr_seen[r.sat_id - 1] = r.snr;
         batch_pos++;
      end
      if (r.batch_end) begin
         batch_pos = 0;
         if (r.time_ms - win_start > {32'd0, win_len}) begin
            // Count and sum first, then clear the store for the next window.
            seen = 0;
            total = 0;
            foreach (snr_seen[i]) begin
               if (snr_seen[i] != '0) begin
                  seen++;
                  total += snr_seen[i];
               end
            end
            if (seen > 63) seen = 63;
            if (total > 8191) total = 8191;
            cur_count = seen[COUNT_W-1:0];
            cur_total = total[TOTAL_W-1:0];
            cur_place = (seen >= thr_count && total >= thr_total) ?
                        PLACE_OUTDOOR : PLACE_INDOOR;
            foreach (snr_seen[i]) snr_seen[i] = '0;
            win_start = r.time_ms;
            v.updated = 1'b1;
         end
      end
      v.place = cur_place;
      v.seen_count = cur_count;
      v.snr_total = cur_total;
      return v;
   endfunction

   // Offers one report after a random gap and waits until the block takes it.
   task automatic send_report(input report_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.snr, r.sat_id, r.time_ms};
      req_tlast <= r.batch_end;
      do @(posedge clock); while (req_tready !== 1'b1);
      verdicts_due.push_back(judge_report(r));
   endtask

   // Stops offering and waits until every outstanding response has come back.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0]  idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_MIN_COUNT: thr_count = value[COUNT_W-1:0];
         CSR_MIN_TOTAL: thr_total = value[TOTAL_W-1:0];
         CSR_WINDOW:    win_len = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Random batches around the current window length, with stray reports mixed in.
   task automatic run_batches(input int n_items);
      int                sent;
      int                len;
      int                k;
      logic [TIME_W-1:0] step;
      report_type        r;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            // A stray report with any timestamp, id and end mark.
            r.time_ms = {$urandom, $urandom};
            r.sat_id = 8'($urandom);
            r.snr = 8'($urandom);
            r.batch_end = 1'($urandom_range(0, 1));
            send_report(r);
            sent++;
         end else begin
            case ($urandom_range(0, 5))
               0: step = '0;
               1: step = 64'($urandom_range(1, 50));
               2: step = 64'(win_len);
               3: step = 64'(win_len) + 64'd1;
               4: step = 64'(win_len) + 64'($urandom_range(2, 5000));
               default: step = 64'($urandom_range(0, win_len));
            endcase
            sky_time += step;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                              : $urandom_range(1, 8);
            for (k = 0; k < len; k++) begin
               r.time_ms = sky_time;
               r.sat_id = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(1, N_SAT));
               case ($urandom_range(0, 4))
                  0: r.snr = '0;
                  1, 2: r.snr = 8'($urandom_range(1, 40));
                  default: r.snr = 8'($urandom);
               endcase
               r.batch_end = (k == len - 1);
               send_report(r);
            end
            sent += len;
         end
      end
   endtask

   // Field extremes, bad ids, unset and wrapped windows, batch ends inside the window.
   task automatic test_directed();
      send_report('{64'd0, 8'd0, 8'd0, 1'b0});
      send_report('{64'd100, 8'd1, 8'd255, 1'b1});
      send_report('{64'd100, 8'd32, 8'd200, 1'b0});
      send_report('{64'd100, 8'd33, 8'd77, 1'b0});
      send_report('{64'd100, 8'd255, 8'd66, 1'b0});
      send_report('{64'd100, 8'd0, 8'd1, 1'b0});
      send_report('{64'd4101, 8'd5, 8'd10, 1'b1});
      // Elapsed time equal to the window does not close it.
      send_report('{64'd8101, 8'd2, 8'd0, 1'b1});
      send_report('{64'd8102, 8'd3, 8'd50, 1'b1});
      send_report('{64'd12200, 8'd10, 8'd30, 1'b0});
      send_report('{64'd12200, 8'd11, 8'd30, 1'b0});
      send_report('{64'd12200, 8'd12, 8'd30, 1'b0});
      send_report('{64'd12200, 8'd13, 8'd30, 1'b1});
      // The timestamp wraps through zero, and the restart at zero leaves the window unset.
      send_report('{64'hFFFF_FFFF_FFFF_F000, 8'd7, 8'd1, 1'b1});
      send_report('{64'd0, 8'd8, 8'd9, 1'b1});
      send_report('{64'd777, 8'd9, 8'd3, 1'b0});
      send_report('{64'hFFFF_FFFF_FFFF_FFFF, 8'd20, 8'd128, 1'b0});
      send_report('{64'd4778, 8'd9, 8'd60, 1'b1});
      settle();
   endtask

   // Threshold and window registers at both ends of their ranges.
   task automatic test_threshold_extremes();
      logic [TIME_W-1:0] t;
      int                k;
      write_csr(CSR_MIN_COUNT, 32'd0);
      write_csr(CSR_MIN_TOTAL, 32'd0);
      write_csr(CSR_WINDOW, 32'd0);
      run_batches(100);
      settle();
      write_csr(CSR_MIN_COUNT, 32'd32);
      write_csr(CSR_MIN_TOTAL, 32'd8160);
      write_csr(CSR_WINDOW, 32'd100);
      // Close the current batch so that full batches start at position zero.
      sky_time += 64'd1000;
      send_report('{sky_time | 64'd1, 8'd0, 8'd0, 1'b1});
      // Every satellite at full strength just reaches both thresholds.
      t = win_start + 64'd101;
      for (k = 1; k <= N_SAT; k++) send_report('{t, 8'(k), 8'd255, 1'(k == N_SAT)});
      t += 64'd101;
      for (k = 1; k <= N_SAT; k++)
         send_report('{t, 8'(k), (k == 17) ? 8'd254 : 8'd255, 1'(k == N_SAT)});
      sky_time = t;
      run_batches(60);
      settle();
      write_csr(CSR_WINDOW, 32'hFFFF_FFFF);
      run_batches(150);
      settle();
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      report_type r;
      int         k;
      write_csr(CSR_WINDOW, 32'd3000);
      no_idle = 1'b1;
      holdoff_armed = 1'b1;
      for (k = 0; k < 40; k++) begin
         sky_time += 64'd1100;
         r.time_ms = sky_time;
         r.sat_id = 8'($urandom_range(1, N_SAT));
         r.snr = 8'($urandom);
         r.batch_end = (k % 4 == 3);
         send_report(r);
      end
      no_idle = 1'b0;
      settle();
   endtask

   // Several random threshold and window settings, one phase without idle cycles.
   task automatic test_random_settings();
      int phase;
      for (phase = 0; phase < 5; phase++) begin
         write_csr(CSR_MIN_COUNT, ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 32))
                                                               : 32'($urandom_range(1, 6)));
         write_csr(CSR_MIN_TOTAL, ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 8160))
                                                               : 32'($urandom_range(40, 200)));
         case ($urandom_range(0, 5))
            0: write_csr(CSR_WINDOW, 32'd0);
            1: write_csr(CSR_WINDOW, 32'hFFFF_FFFF);
            default: write_csr(CSR_WINDOW, 32'($urandom_range(0, 6000)));
         endcase
         no_idle = (phase == 2);
         run_batches(250);
         settle();
      end
      no_idle = 1'b0;
   endtask

   // Response ready with random stalls, and the long hold-off when armed.
   initial begin : rsp_ready_drive
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= (stall_left == 0) && !hold_rsp;
         if (stall_left > 0) stall_left--;
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            stall_left = no_idle ? 0 : $urandom_range(0, 3);
      end
   end

   // Counts out the long hold-off of the response stream.
   initial begin : rsp_holdoff
      forever begin
         @(posedge clock);
         if (holdoff_armed) begin
            holdoff_armed = 1'b0;
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
      end
   end

   // Compares each accepted response with the oldest outstanding prediction.
   initial begin : verdict_check
      verdict_type got;
      verdict_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            got = verdict_type'(rsp_tdata);
            if (verdicts_due.size() == 0) begin
               misfits++;
               if (misfits <= 10) $display("Response %h arrived with no request outstanding",
                                           rsp_tdata);
            end else begin
               want = verdicts_due.pop_front();
               if (got.updated !== want.updated || got.place !== want.place ||
                   got.seen_count !== want.seen_count || got.snr_total !== want.snr_total ||
                   got.fill !== want.fill) begin
                  misfits++;
                  if (misfits <= 10) begin
                     $display("Mismatch: expected upd %0d place %0d count %0d total %0d",
                              want.updated, want.place, want.seen_count, want.snr_total);
                     $display("          got upd %0d place %0d count %0d total %0d fill %0d",
                              got.updated, got.place, got.seen_count, got.snr_total,
                              got.fill);
                  end
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_MIN_COUNT;
      csr_wdata = '0;
      foreach (snr_seen[i]) snr_seen[i] = '0;
      win_start = '0;
      cur_place = PLACE_UNDEF;
      cur_count = '0;
      cur_total = '0;
      batch_pos = 0;
      thr_count = MIN_COUNT_RESET;
      thr_total = MIN_TOTAL_RESET;
      win_len = WINDOW_RESET;
      sky_time = 64'd20000;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_threshold_extremes();
      test_backpressure();
      test_random_settings();

      settle();
      repeat (40) @(posedge clock);
      if (misfits == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/gioc_pkg.sv
sv/gioc_ctrl.sv
sv/gioc_dp.sv
sv/gnss_indoor_outdoor_classifier.sv
tb/gnss_indoor_outdoor_classifier_test.sv
